### design/dta_pkg.sv
// Shared types, constants and helper functions of the dihedral angle pipeline.
package dta_pkg;

	localparam int COORD_W = 24;
	localparam int T_W = 51;
	localparam int CORDIC_STAGES = 24;
	localparam int ROOT_W = 31;
	localparam int SQ_W = 62;

	localparam logic [5:0] NRM_MSB = 6'd19;
	localparam logic [5:0] JNT_MSB = 6'd29;

	localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [32:0] ROUND_Q30 = 33'd65536;

	typedef struct packed {
		logic valid;
		logic degen;
		logic neg;
	} ctl_t;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] v;
		case (i)
			0: v = 34'sd843314856;
			1: v = 34'sd497837829;
			2: v = 34'sd263043836;
			3: v = 34'sd133525158;
			4: v = 34'sd67021686;
			5: v = 34'sd33543515;
			6: v = 34'sd16775850;
			7: v = 34'sd8388437;
			8: v = 34'sd4194282;
			9: v = 34'sd2097149;
			10: v = 34'sd1048575;
			11: v = 34'sd524287;
			12: v = 34'sd262143;
			13: v = 34'sd131071;
			14: v = 34'sd65535;
			15: v = 34'sd32767;
			16: v = 34'sd16383;
			17: v = 34'sd8191;
			18: v = 34'sd4095;
			19: v = 34'sd2047;
			20: v = 34'sd1023;
			21: v = 34'sd511;
			22: v = 34'sd255;
			23: v = 34'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [5:0] msb_pos(input logic [50:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 51; i++) begin
			if (m[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

### design/dta_cross.sv
// Difference vectors, the two plane normals and the exact sign test of t1 dot r4.
module dta_cross import dta_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [287:0]          pts,
	output ctl_t                  ctl,
	output logic signed [T_W-1:0] t1 [3],
	output logic signed [T_W-1:0] t2 [3]
);

	logic signed [COORD_W-1:0] p [4][3];
	logic signed [24:0] r1_s1 [3], r2_s1 [3], r4_s1 [3];
	logic signed [49:0] pa_s2 [3], pb_s2 [3], qa_s2 [3], qb_s2 [3];
	logic signed [24:0] r4_s2 [3], r4_s3 [3];
	logic signed [T_W-1:0] t1_s3 [3], t2_s3 [3], t1_s4 [3], t2_s4 [3];
	logic signed [T_W-1:0] t1_s5 [3], t2_s5 [3];
	logic signed [50:0] hp_s4 [3], lp_s4 [3];
	logic signed [52:0] hs_s5, ls_s5;
	logic signed [77:0] tot;
	logic v_s1, v_s2, v_s3;
	ctl_t c_s4, c_s5, c_s6;
	logic degen;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 3; k++) begin
				p[j][k] = $signed(pts[(j * 3 + k) * COORD_W +: COORD_W]);
			end
		end
	end

	always_comb begin
		degen = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (t1_s3[k] != '0) degen = 1'b0;
		end
		if (t2_s3[0] == '0 && t2_s3[1] == '0 && t2_s3[2] == '0) degen = 1'b1;
	end

	assign tot = 78'({hs_s5, 25'd0}) + 78'(ls_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			c_s4 <= '0;
			c_s5 <= '0;
			c_s6 <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			c_s4 <= '{valid: v_s3, degen: degen, neg: 1'b0};
			c_s5 <= c_s4;
			c_s6 <= '{valid: c_s5.valid, degen: c_s5.degen, neg: tot[77]};
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				r1_s1[k] <= 25'(p[0][k]) - 25'(p[1][k]);
				r2_s1[k] <= 25'(p[2][k]) - 25'(p[1][k]);
				r4_s1[k] <= 25'(p[3][k]) - 25'(p[2][k]);
				pa_s2[k] <= r1_s1[K1] * r2_s1[K2];
				pb_s2[k] <= r1_s1[K2] * r2_s1[K1];
				// r3 = -r2, so t2 = r3 x r4 = r4 x r2.
				qa_s2[k] <= r4_s1[K1] * r2_s1[K2];
				qb_s2[k] <= r4_s1[K2] * r2_s1[K1];
				r4_s2[k] <= r4_s1[k];
				t1_s3[k] <= 51'(pa_s2[k]) - 51'(pb_s2[k]);
				t2_s3[k] <= 51'(qa_s2[k]) - 51'(qb_s2[k]);
				r4_s3[k] <= r4_s2[k];
				// t1 is split into a signed high part and an unsigned low part.
				hp_s4[k] <= 51'($signed(t1_s3[k][50:25])) * 51'(r4_s3[k]);
				lp_s4[k] <= 51'($signed({1'b0, t1_s3[k][24:0]})) * 51'(r4_s3[k]);
				t1_s4[k] <= t1_s3[k];
				t2_s4[k] <= t2_s3[k];
				t1_s5[k] <= t1_s4[k];
				t2_s5[k] <= t2_s4[k];
				t1[k] <= t1_s5[k];
				t2[k] <= t2_s5[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s5 <= 53'(hp_s4[0]) + 53'(hp_s4[1]) + 53'(hp_s4[2]);
			ls_s5 <= 53'(lp_s4[0]) + 53'(lp_s4[1]) + 53'(lp_s4[2]);
		end
	end

	assign ctl = c_s6;

endmodule

### design/dta_dot.sv
// Normal reduction, dot and cross product of the normals, joint reduction and squares.
module dta_dot import dta_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  ctl_t                   ctl_in,
	input  logic signed [T_W-1:0]  t1 [3],
	input  logic signed [T_W-1:0]  t2 [3],
	output ctl_t                   ctl,
	output logic signed [30:0]     xs,
	output logic [SQ_W-1:0]        sq
);

	ctl_t c_d [1:10];
	logic [50:0] ma_d1 [3], mb_d1 [3], ma_d2 [3], mb_d2 [3];
	logic na_d1 [3], nb_d1 [3], na_d2 [3], nb_d2 [3];
	logic [50:0] ora_d1, orb_d1;
	logic [5:0] sa_d2, sb_d2, msa, msb;
	logic signed [20:0] a_d3 [3], b_d3 [3];
	logic signed [41:0] xp_d4 [3], ca_d4 [3], cb_d4 [3];
	logic signed [42:0] x_d5, c_d5 [3];
	logic [41:0] mx_d6, mc_d6 [3], mx_d7, mc_d7 [3];
	logic nx_d6, nx_d7;
	logic [41:0] or_d6;
	logic [5:0] sj_d7, msj;
	logic [41:0] xr, cr [3];
	logic signed [30:0] xs_d8, xs_d9, xs_d10;
	logic [29:0] cm_d8 [3];
	logic [59:0] sq_d9 [3];
	logic [SQ_W-1:0] sq_d10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 10; i++) c_d[i] <= '0;
		end else if (en) begin
			c_d[1] <= ctl_in;
			for (int i = 2; i <= 10; i++) c_d[i] <= c_d[i - 1];
		end
	end

	always_comb begin
		msa = msb_pos(ora_d1);
		msb = msb_pos(orb_d1);
		msj = msb_pos(51'(or_d6));
		xr = mx_d7 >> sj_d7;
		for (int k = 0; k < 3; k++) cr[k] = mc_d7[k] >> sj_d7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ora_d1 <= 51'(t1[0][50] ? -t1[0] : t1[0]) | 51'(t1[1][50] ? -t1[1] : t1[1])
				| 51'(t1[2][50] ? -t1[2] : t1[2]);
			orb_d1 <= 51'(t2[0][50] ? -t2[0] : t2[0]) | 51'(t2[1][50] ? -t2[1] : t2[1])
				| 51'(t2[2][50] ? -t2[2] : t2[2]);
			sa_d2 <= (msa >= NRM_MSB) ? msa - NRM_MSB : 6'd0;
			sb_d2 <= (msb >= NRM_MSB) ? msb - NRM_MSB : 6'd0;
			x_d5 <= 43'(xp_d4[0]) + 43'(xp_d4[1]) + 43'(xp_d4[2]);
			mx_d6 <= x_d5[42] ? 42'(-x_d5) : 42'(x_d5);
			nx_d6 <= x_d5[42];
			or_d6 <= (x_d5[42] ? 42'(-x_d5) : 42'(x_d5))
				| (c_d5[0][42] ? 42'(-c_d5[0]) : 42'(c_d5[0]))
				| (c_d5[1][42] ? 42'(-c_d5[1]) : 42'(c_d5[1]))
				| (c_d5[2][42] ? 42'(-c_d5[2]) : 42'(c_d5[2]));
			mx_d7 <= mx_d6;
			nx_d7 <= nx_d6;
			sj_d7 <= (msj >= JNT_MSB) ? msj - JNT_MSB : 6'd0;
			xs_d8 <= nx_d7 ? -$signed({1'b0, xr[29:0]}) : $signed({1'b0, xr[29:0]});
			xs_d9 <= xs_d8;
			sq_d10 <= 62'(sq_d9[0]) + 62'(sq_d9[1]) + 62'(sq_d9[2]);
			xs_d10 <= xs_d9;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;
		logic [50:0] sha, shb;
		assign sha = ma_d2[k] >> sa_d2;
		assign shb = mb_d2[k] >> sb_d2;
		always_ff @(posedge clk) begin
			if (en) begin
				ma_d1[k] <= 51'(t1[k][50] ? -t1[k] : t1[k]);
				mb_d1[k] <= 51'(t2[k][50] ? -t2[k] : t2[k]);
				na_d1[k] <= t1[k][50];
				nb_d1[k] <= t2[k][50];
				ma_d2[k] <= ma_d1[k];
				mb_d2[k] <= mb_d1[k];
				na_d2[k] <= na_d1[k];
				nb_d2[k] <= nb_d1[k];
				a_d3[k] <= na_d2[k] ? -$signed({1'b0, sha[19:0]}) : $signed({1'b0, sha[19:0]});
				b_d3[k] <= nb_d2[k] ? -$signed({1'b0, shb[19:0]}) : $signed({1'b0, shb[19:0]});
				xp_d4[k] <= 42'(a_d3[k]) * 42'(b_d3[k]);
				ca_d4[k] <= 42'(a_d3[K1]) * 42'(b_d3[K2]);
				cb_d4[k] <= 42'(a_d3[K2]) * 42'(b_d3[K1]);
				c_d5[k] <= 43'(ca_d4[k]) - 43'(cb_d4[k]);
				mc_d6[k] <= c_d5[k][42] ? 42'(-c_d5[k]) : 42'(c_d5[k]);
				mc_d7[k] <= mc_d6[k];
				cm_d8[k] <= cr[k][29:0];
				sq_d9[k] <= 60'(cm_d8[k]) * 60'(cm_d8[k]);
			end
		end
	end

	assign ctl = c_d[10];
	assign xs = xs_d10;
	assign sq = sq_d10;

endmodule

### design/dta_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module dta_isqrt import dta_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ctl_t                ctl_in,
	input  logic signed [30:0]  xs_in,
	input  logic [SQ_W-1:0]     sq,
	output ctl_t                ctl,
	output logic signed [30:0]  xs,
	output logic [ROOT_W-1:0]   root
);

	ctl_t c_p [ROOT_W + 1];
	logic signed [30:0] x_p [ROOT_W + 1];
	logic [SQ_W-1:0] rem_p [ROOT_W + 1];
	logic [ROOT_W-1:0] rt_p [ROOT_W + 1];

	assign c_p[0] = ctl_in;
	assign x_p[0] = xs_in;
	assign rem_p[0] = sq;
	assign rt_p[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int I = ROOT_W - 1 - j;
		logic [SQ_W:0] trial;
		logic fits;
		assign trial = ((SQ_W + 1)'(rt_p[j]) << (I + 1)) + ((SQ_W + 1)'(1) << (2 * I));
		assign fits = {1'b0, rem_p[j]} >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_p[j + 1] <= '0;
			end else if (en) begin
				c_p[j + 1] <= c_p[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_p[j + 1] <= x_p[j];
				rem_p[j + 1] <= fits ? SQ_W'({1'b0, rem_p[j]} - trial) : rem_p[j];
				rt_p[j + 1] <= fits ? (rt_p[j] | (ROOT_W'(1) << I)) : rt_p[j];
			end
		end
	end

	assign ctl = c_p[ROOT_W];
	assign xs = x_p[ROOT_W];
	assign root = rt_p[ROOT_W];

endmodule

### design/dta_cordic.sv
// CORDIC vectoring of (x, root) to an angle, then clamping, rounding and sign.
module dta_cordic import dta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ctl_t               ctl_in,
	input  logic signed [30:0] xs,
	input  logic [ROOT_W-1:0]  root,
	output ctl_t               ctl,
	output logic signed [15:0] angle
);

	ctl_t c_p [CORDIC_STAGES + 1];
	ctl_t c_f;
	logic signed [33:0] x_p [CORDIC_STAGES + 1];
	logic signed [33:0] y_p [CORDIC_STAGES + 1];
	logic signed [33:0] z_p [CORDIC_STAGES + 1];
	logic [31:0] zc;
	logic [32:0] rnd;
	logic signed [15:0] mag, ang_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_p[0] <= '0;
		end else if (en) begin
			c_p[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (xs < 0) begin
				x_p[0] <= 34'($signed({1'b0, root}));
				y_p[0] <= -34'(xs);
				z_p[0] <= HALF_PI_Q30;
			end else begin
				x_p[0] <= 34'(xs);
				y_p[0] <= 34'($signed({1'b0, root}));
				z_p[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		logic signed [33:0] dx, dy;
		assign dx = y_p[i] >>> i;
		assign dy = x_p[i] >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_p[i + 1] <= '0;
			end else if (en) begin
				c_p[i + 1] <= c_p[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_p[i] > 0) begin
					x_p[i + 1] <= x_p[i] + dx;
					y_p[i + 1] <= y_p[i] - dy;
					z_p[i + 1] <= z_p[i] + atan_q30(i);
				end else begin
					x_p[i + 1] <= x_p[i] - dx;
					y_p[i + 1] <= y_p[i] + dy;
					z_p[i + 1] <= z_p[i] - atan_q30(i);
				end
			end
		end
	end

	always_comb begin
		if (z_p[CORDIC_STAGES] < 0) begin
			zc = '0;
		end else if (z_p[CORDIC_STAGES] > PI_Q30) begin
			zc = 32'(PI_Q30);
		end else begin
			zc = 32'(z_p[CORDIC_STAGES]);
		end
		rnd = 33'(zc) + ROUND_Q30;
		mag = $signed(rnd[32:17]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_f <= '0;
		end else if (en) begin
			c_f <= c_p[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (c_p[CORDIC_STAGES].degen) begin
				ang_f <= '0;
			end else if (c_p[CORDIC_STAGES].neg) begin
				ang_f <= mag;
			end else begin
				ang_f <= -mag;
			end
		end
	end

	assign ctl = c_f;
	assign angle = ang_f;

endmodule

### design/dihedral_torsion_angle.sv
// Dihedral angle of four 3-D points: top level with pipeline and output buffering.
// An accepted input item passes 73 pipeline stages and the output register to m_tvalid.
// Throughput: one item per cycle while the skid register is empty, set by the fully
// pipelined square root (one bit per stage) and CORDIC (one iteration per stage).
// Reset: arst_n clears all valid bits, including those of the output and skid registers,
// asynchronously; the block accepts items from the first cycle after reset is released.
module dihedral_torsion_angle import dta_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0 up: p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
	// p4_x, p4_y, p4_z; each 24 bits, signed Q11.12.
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0 up: angle, 16 bits, signed Q2.13 radians.
	output logic [15:0]  m_tdata,
	// Fields from bit 0 up: degenerate, 1 bit.
	output logic [0:0]   m_tuser
);

	// The whole pipeline advances together whenever the skid register is empty.
	// An item leaving the last stage goes to the output register when that is free
	// or being taken, and otherwise to the skid register, which then stalls the
	// pipeline until the output register drains it.
	logic en;
	ctl_t cr_ctl, dt_ctl, sq_ctl, fin_ctl;
	logic signed [T_W-1:0] t1 [3], t2 [3];
	logic signed [30:0] xs_dt, xs_sq;
	logic [SQ_W-1:0] sq_dt;
	logic [ROOT_W-1:0] root;
	logic signed [15:0] angle;
	logic out_v_q, skid_v_q;
	logic [15:0] out_a_q, skid_a_q;
	logic out_d_q, skid_d_q;
	logic fin_take, out_free;

	assign en = !skid_v_q;
	assign s_tready = en;

	// Normals and the sign of the angle.
	dta_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.pts      (s_tdata),
		.ctl      (cr_ctl),
		.t1       (t1),
		.t2       (t2)
	);

	// Reduced cosine numerator and squared sine numerator.
	dta_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (cr_ctl),
		.t1     (t1),
		.t2     (t2),
		.ctl    (dt_ctl),
		.xs     (xs_dt),
		.sq     (sq_dt)
	);

	dta_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (dt_ctl),
		.xs_in  (xs_dt),
		.sq     (sq_dt),
		.ctl    (sq_ctl),
		.xs     (xs_sq),
		.root   (root)
	);

	dta_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (sq_ctl),
		.xs     (xs_sq),
		.root   (root),
		.ctl    (fin_ctl),
		.angle  (angle)
	);

	// An item leaves the last stage only in a cycle in which the pipeline advances.
	assign fin_take = fin_ctl.valid && en;
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fin_take;
			end
		end else if (fin_take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_a_q <= skid_a_q;
				out_d_q <= skid_d_q;
			end else begin
				out_a_q <= angle;
				out_d_q <= fin_ctl.degen;
			end
		end else if (fin_take) begin
			skid_a_q <= angle;
			skid_d_q <= fin_ctl.degen;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_a_q;
	assign m_tuser = out_d_q;

endmodule

### test/dta_checker.sv
// Checker for the dihedral angle block: predicts each angle and compares it with the output.
`timescale 1ns / 1ps
module dta_checker import dta_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [287:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [15:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending
);

	typedef struct packed {
		logic [15:0] angle;
		logic        degen;
	} torsion_t;

	torsion_t angle_queue[$];

	localparam longint ARC_Q30[24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127};

	function automatic longint trunc_shift(longint v, int s);
		longint m;
		m = (v < 0 ? -v : v) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic int shift_to_fit(longint m, int bits);
		int s;
		s = 0;
		while ((m >>> s) >= (64'sd1 <<< bits)) s++;
		return s;
	endfunction

	function automatic longint int_root(longint n);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--)
			if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= n) r += 64'sd1 <<< b;
		return r;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Torsion of four points; the coordinates are at most 25-bit differences, so
	// the normals fit 51 bits and their dot with r4 fits 76 bits, held in 128.
	function automatic torsion_t torsion_of(logic [287:0] d);
		longint p[12], r1[3], r2[3], r3[3], r4[3], t1[3], t2[3], a[3], b[3], c[3];
		longint xs, x, y, z, dx, dy, mag, m1, m2, mj, sq, ck;
		logic signed [127:0] sgn;
		int s1, s2, sj;
		torsion_t res;
		for (int k = 0; k < 12; k++) p[k] = longint'($signed(d[k*24 +: 24]));
		for (int k = 0; k < 3; k++) begin
			r1[k] = p[k] - p[3+k];
			r2[k] = p[6+k] - p[3+k];
			r3[k] = p[3+k] - p[6+k];
			r4[k] = p[9+k] - p[6+k];
		end
		t1[0] = r1[1]*r2[2] - r1[2]*r2[1];
		t1[1] = r1[2]*r2[0] - r1[0]*r2[2];
		t1[2] = r1[0]*r2[1] - r1[1]*r2[0];
		t2[0] = r3[1]*r4[2] - r3[2]*r4[1];
		t2[1] = r3[2]*r4[0] - r3[0]*r4[2];
		t2[2] = r3[0]*r4[1] - r3[1]*r4[0];
		m1 = 0;
		m2 = 0;
		for (int k = 0; k < 3; k++) begin
			if (absl(t1[k]) > m1) m1 = absl(t1[k]);
			if (absl(t2[k]) > m2) m2 = absl(t2[k]);
		end
		if (m1 == 0 || m2 == 0) begin
			res.angle = '0;
			res.degen = 1'b1;
			return res;
		end
		s1 = shift_to_fit(m1, 20);
		s2 = shift_to_fit(m2, 20);
		for (int k = 0; k < 3; k++) begin
			a[k] = trunc_shift(t1[k], s1);
			b[k] = trunc_shift(t2[k], s2);
		end
		xs = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
		c[0] = a[1]*b[2] - a[2]*b[1];
		c[1] = a[2]*b[0] - a[0]*b[2];
		c[2] = a[0]*b[1] - a[1]*b[0];
		mj = absl(xs);
		for (int k = 0; k < 3; k++) if (absl(c[k]) > mj) mj = absl(c[k]);
		sj = shift_to_fit(mj, 30);
		xs = trunc_shift(xs, sj);
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			ck = trunc_shift(c[k], sj);
			sq += ck * ck;
		end
		// Rotate into the right half plane first when the cosine is negative.
		if (xs < 0) begin
			x = int_root(sq);
			y = -xs;
			z = 64'sd1686629713;
		end else begin
			x = xs;
			y = int_root(sq);
			z = 0;
		end
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += ARC_Q30[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ARC_Q30[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 64'sd3373259426) z = 64'sd3373259426;
		mag = (z + 65536) >>> 17;
		sgn = 0;
		for (int k = 0; k < 3; k++) sgn += 128'(signed'(t1[k])) * 128'(signed'(r4[k]));
		if (!(sgn < 0)) mag = -mag;
		res.angle = mag[15:0];
		res.degen = 1'b0;
		return res;
	endfunction

	assign pending = angle_queue.size();

	always @(posedge clk or negedge arst_n) begin
		torsion_t exp_res;
		if (!arst_n) begin
			fail_count <= 0;
			angle_queue.delete();
		end else begin
			if (s_tvalid && s_tready)
				angle_queue.insert(angle_queue.size(), torsion_of(s_tdata));
			if (m_tvalid && m_tready) begin
				if (angle_queue.size() == 0) begin
					$display("%0t: unexpected result angle=%0d degenerate=%0b",
						$time, $signed(m_tdata), m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = angle_queue.pop_front();
					if (exp_res.angle !== m_tdata || exp_res.degen !== m_tuser[0]) begin
						$display("%0t: expected angle=%0d degenerate=%0b, actual angle=%0d degenerate=%0b",
							$time, $signed(exp_res.angle), exp_res.degen,
							$signed(m_tdata), m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### test/tb_top.sv
// Top of the dihedral angle testbench: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_top;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count;
	int           pending;
	int           quiet_cycles;

	// The watchdog allows far more than the longest gap plus the longest receiver
	// stall plus the latency of the block through its pipeline.
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;

	dihedral_torsion_angle i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	dta_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Packs four points, p1 first in the lowest bits.
	function automatic logic [287:0] pack_points(logic [23:0] c[12]);
		logic [287:0] d;
		for (int k = 0; k < 12; k++) d[k*24 +: 24] = c[k];
		return d;
	endfunction

	// Offers one item and holds it until it is taken.
	task automatic send_item(logic [287:0] d);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Random coordinate: mostly within the spread around 0 or 4096 so geometry stays meaningful,
	// sometimes anywhere in the full 24-bit range.
	function automatic logic [23:0] rand_coord(int spread);
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 2*spread)) - spread);
			default: return 24'($signed($urandom_range(0, 2*spread)) - spread + 4096);
		endcase
	endfunction

	task automatic send_random;
		logic [23:0] c[12];
		int spread, kind;
		spread = ($urandom_range(0, 3) == 0) ? 8388607 : (1 << $urandom_range(2, 16));
		kind = $urandom_range(0, 15);
		for (int k = 0; k < 12; k++) c[k] = rand_coord(spread);
		// Special shapes: coincident middle points, collinear first three points,
		// planar cis/trans arrangements where the sign product is zero.
		if (kind == 0) for (int k = 0; k < 3; k++) c[6+k] = c[3+k];
		if (kind == 1) for (int k = 0; k < 3; k++) c[k] = 24'(2*$signed(c[3+k]) - $signed(c[6+k]));
		if (kind == 2) begin
			c[2] = c[5];
			c[8] = c[5];
			c[11] = c[5];
		end
		send_item(pack_points(c));
	endtask

	// Receiver stalls in a pattern of its own: runs of ready and of stall.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if ($urandom_range(0, 3) != 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Watchdog: cycles with no accepted item on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [23:0] c[12];
		int burst;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, all-zero, cis, trans, plus and minus ninety degrees,
		// the degenerate collinear case and tiny cross products.
		for (int k = 0; k < 12; k++) c[k] = 24'h7FFFFF;
		send_item(pack_points(c));
		for (int k = 0; k < 12; k++) c[k] = 24'h800000;
		send_item(pack_points(c));
		for (int k = 0; k < 12; k++) c[k] = (k % 2) ? 24'h800000 : 24'h7FFFFF;
		send_item(pack_points(c));
		for (int k = 0; k < 12; k++) c[k] = (k % 3 == k / 3 % 3) ? 24'h7FFFFF : 24'h800000;
		send_item(pack_points(c));
		for (int k = 0; k < 12; k++) c[k] = (k % 4 == 1) ? 24'h800000 : 24'h7FFFFF;
		send_item(pack_points(c));
		send_item('0);
		// Trans: p1=(1,1,0) p2=(0,0,0) p3=(1,0,0)... planar, zero sign product.
		c = '{24'd4096, 24'd4096, 0, 0, 0, 0, 24'd4096, 0, 0, 24'd4096, -24'sd4096, 0};
		send_item(pack_points(c));
		// Cis variant, magnitude zero.
		c = '{24'd4096, 24'd4096, 0, 0, 0, 0, 24'd4096, 0, 0, 24'd4096, 24'd4096, 0};
		send_item(pack_points(c));
		// Plus and minus ninety degrees.
		c = '{0, 24'd4096, 0, 0, 0, 0, 24'd4096, 0, 0, 24'd4096, 0, 24'd4096};
		send_item(pack_points(c));
		c = '{0, 24'd4096, 0, 0, 0, 0, 24'd4096, 0, 0, 24'd4096, 0, -24'sd4096};
		send_item(pack_points(c));
		// Collinear first three points.
		c = '{24'd1, 24'd1, 24'd1, 24'd2, 24'd2, 24'd2, 24'd3, 24'd3, 24'd3, 0, 24'd7, 0};
		send_item(pack_points(c));
		// Tiny cross products in a huge box.
		c = '{24'h7FFFFF, 0, 0, 0, 0, 0, 24'd1, 0, 0, 24'd1, 24'd1, 24'd1};
		send_item(pack_points(c));
		s_tvalid <= 1'b0;

		// Pause until every expected result has arrived.
		while (pending != 0) @(posedge clk);

		// Random part in bursts with random gaps; one phase runs without gaps.
		for (int n = 0; n < 1200; ) begin
			burst = $urandom_range(1, 60);
			for (int j = 0; j < burst; j++) send_random();
			n += burst;
			if (n < 300 || n > 600) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
